// ----- sv/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Buffer geometry, cell codes, and the command/status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    // Screen geometry
    localparam int TEXT_ROWS    = 25;
    localparam int TEXT_COLUMNS = 79;
    localparam int ROW_PITCH    = 80;
    localparam int CELL_COUNT   = TEXT_ROWS * ROW_PITCH;
    localparam int ADDR_W       = $clog2(CELL_COUNT);

    // Field widths
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;

    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [CELL_W-1:0] cell_t;

    // Cell codes
    localparam char_t NEWLINE_CODE = 8'h0A;
    localparam char_t SPACE_CODE   = 8'h20;
    localparam char_t ATTR_RESET   = 8'h1F;
    localparam cell_t RESET_CELL   = 16'h1F20;

    localparam row_t  LAST_ROW  = row_t'(TEXT_ROWS - 1);
    localparam col_t  LAST_COL  = col_t'(TEXT_COLUMNS - 1);
    localparam addr_t LAST_ADDR = addr_t'(CELL_COUNT - 1);
    localparam addr_t PITCH_A   = addr_t'(ROW_PITCH);

    // Operation codes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic clear_en;   // write reset cell at clear pointer
        logic capture;    // latch the input word
        logic exec;       // run the put or issue the read
        logic copy_en;    // issue one scroll copy read
        logic blank_en;   // blank one bottom-row cell
        logic load_out;   // load the result register
    } tcw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic need_scroll;
        logic copy_last;
        logic col_last;
    } tcw_stat_t;

    // Linear cell address of (row, col)
    function automatic addr_t cell_addr(input row_t row, input col_t col);
        cell_addr = addr_t'(addr_t'(row) * PITCH_A + addr_t'(col));
    endfunction

endpackage

`default_nettype wire

// ----- sv/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console with cursor and scroll-up
// Top level: ties the sequencer and the datapath together and decodes the
// APB-style attribute register.
// ----------------------------------------------------------------------------
// Words are handled one at a time. After reset a clearing pass writes the
// reset cell into all 2000 buffer entries, one per cycle, and s_ready stays
// low until the pass is done (register writes are taken meanwhile). For a
// read or a put without scroll, the word passes through the EXEC and FINISH
// states; the result word is loaded into the output register at the same
// edge at which s_ready rises again, and it can wait there while the next
// word is accepted. For a put that scrolls, the single-write-port cell
// memory copies 24 x 79 cells at one per cycle, spends the DRAIN state on
// the last copy write, then blanks 79 bottom-row cells, one per cycle. A
// result word still waiting on m_ready holds back the next word's result
// and with it the next s_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // input channel
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_operation,
    input  wire tcw_pkg::char_t      s_char_code,
    input  wire tcw_pkg::row_t       s_cell_row,
    input  wire tcw_pkg::col_t       s_cell_col,
    // result channel
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tcw_pkg::cell_t           m_cell_value,
    output tcw_pkg::col_t            m_cursor_col,
    output tcw_pkg::row_t            m_cursor_row,
    output logic                     m_scrolled,
    // configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import tcw_pkg::*;

    tcw_cmd_t  cmd;
    tcw_stat_t stat;
    char_t     text_attribute;
    logic      attr_sel;
    logic      attr_we;

    // Register decode: attribute at byte addresses 0 to 3 (paddr[2] low)
    assign attr_sel = (paddr[2] == 1'b0);
    assign attr_we  = psel && penable && pwrite && attr_sel;
    assign pready   = 1'b1;
    assign prdata   = attr_sel ? {24'b0, text_attribute} : 32'b0;

    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tcw_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .in_operation   (s_operation),
        .in_char_code   (s_char_code),
        .in_cell_row    (s_cell_row),
        .in_cell_col    (s_cell_col),
        .attr_we        (attr_we),
        .attr_wdata     (pwdata[7:0]),
        .text_attribute (text_attribute),
        .out_cell_value (m_cell_value),
        .out_cursor_col (m_cursor_col),
        .out_cursor_row (m_cursor_row),
        .out_scrolled   (m_scrolled)
    );

endmodule

`default_nettype wire

// ----- sv/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl: sequencer for the text console writer
// Runs the post-reset clear pass, steps through one word at a time,
// sequences scroll copy and bottom-row blanking, and owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire tcw_pkg::tcw_stat_t stat,
    output tcw_pkg::tcw_cmd_t       cmd
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_DRAIN,
        ST_BLANK,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (stat.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.need_scroll ? ST_SCROLL : ST_FINISH;
            end
            ST_SCROLL: begin
                cmd.copy_en = 1'b1;
                if (stat.copy_last) state_next = ST_DRAIN;
            end
            // last copy write lands here
            ST_DRAIN: begin
                state_next = ST_BLANK;
            end
            ST_BLANK: begin
                cmd.blank_en = 1'b1;
                if (stat.col_last) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Handshake flags
    always_comb begin
        s_ready_next = (state_next == ST_IDLE);
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (cmd.load_out) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ----- sv/tcw_datapath.sv -----
// ----------------------------------------------------------------------------
// tcw_datapath: cell buffer, cursor and result register
// Single-port-write, registered-read cell memory, cursor update, scroll
// copy pointers, attribute register and the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_datapath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tcw_pkg::tcw_cmd_t cmd,
    output tcw_pkg::tcw_stat_t     stat,
    // input word
    input  wire logic              in_operation,
    input  wire tcw_pkg::char_t    in_char_code,
    input  wire tcw_pkg::row_t     in_cell_row,
    input  wire tcw_pkg::col_t     in_cell_col,
    // attribute register
    input  wire logic              attr_we,
    input  wire tcw_pkg::char_t    attr_wdata,
    output tcw_pkg::char_t         text_attribute,
    // result word
    output tcw_pkg::cell_t         out_cell_value,
    output tcw_pkg::col_t          out_cursor_col,
    output tcw_pkg::row_t          out_cursor_row,
    output logic                   out_scrolled
);
    import tcw_pkg::*;

    cell_t buf_mem [CELL_COUNT];
    cell_t rdata_reg;

    // captured word
    logic  op_reg;
    char_t char_reg;
    row_t  rrow_reg;
    col_t  rcol_reg;

    row_t  cur_row_reg, cur_row_next;
    col_t  cur_col_reg, cur_col_next;
    char_t attr_reg;
    addr_t clear_addr_reg;

    row_t  scan_row_reg;
    col_t  scan_col_reg;
    logic  copy_pend_reg;
    addr_t copy_dst_reg;

    logic  read_hit_reg;
    logic  scrolled_reg;

    cell_t out_value_reg;
    col_t  out_col_reg;
    row_t  out_row_reg;
    logic  out_scr_reg;

    logic  is_newline, is_char, in_range, need_scroll;
    logic  we, re;
    addr_t waddr, raddr, copy_src;
    cell_t wdata;

    assign is_newline  = (op_reg == OP_PUT) && (char_reg == NEWLINE_CODE);
    assign is_char     = (op_reg == OP_PUT) && (char_reg != NEWLINE_CODE);
    assign in_range    = (rrow_reg < row_t'(TEXT_ROWS)) && (rcol_reg < col_t'(ROW_PITCH));
    assign need_scroll = (cur_row_reg == LAST_ROW) &&
                         (is_newline || (is_char && cur_col_reg == LAST_COL));
    assign copy_src    = cell_addr(scan_row_reg, scan_col_reg);

    assign stat.clear_last  = (clear_addr_reg == LAST_ADDR);
    assign stat.need_scroll = need_scroll;
    assign stat.copy_last   = (scan_row_reg == LAST_ROW) && (scan_col_reg == LAST_COL);
    assign stat.col_last    = (scan_col_reg == LAST_COL);

    // Memory write port select
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (cmd.clear_en) begin
            we    = 1'b1;
            waddr = clear_addr_reg;
            wdata = RESET_CELL;
        end else if (copy_pend_reg) begin
            we    = 1'b1;
            waddr = copy_dst_reg;
            wdata = rdata_reg;
        end else if (cmd.blank_en) begin
            we    = 1'b1;
            waddr = cell_addr(LAST_ROW, scan_col_reg);
            wdata = {attr_reg, SPACE_CODE};
        end else if (cmd.exec && is_char) begin
            we    = 1'b1;
            waddr = cell_addr(cur_row_reg, cur_col_reg);
            wdata = {attr_reg, char_reg};
        end
    end

    // Memory read port select
    always_comb begin
        re    = 1'b0;
        raddr = copy_src;
        if (cmd.copy_en) begin
            re = 1'b1;
        end else if (cmd.exec && op_reg == OP_READ && in_range) begin
            re    = 1'b1;
            raddr = cell_addr(rrow_reg, rcol_reg);
        end
    end

    // Cell memory
    always_ff @(posedge aclk) begin
        if (we) buf_mem[waddr] <= wdata;
        if (re) rdata_reg <= buf_mem[raddr];
    end

    // Cursor update for a put
    always_comb begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        if (is_newline || (is_char && cur_col_reg == LAST_COL)) begin
            cur_col_next = '0;
            if (cur_row_reg != LAST_ROW) cur_row_next = cur_row_reg + row_t'(1);
        end else if (is_char) begin
            cur_col_next = cur_col_reg + col_t'(1);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            attr_reg       <= ATTR_RESET;
            clear_addr_reg <= '0;
            copy_pend_reg  <= 1'b0;
        end else begin
            if (attr_we) attr_reg <= attr_wdata;
            if (cmd.clear_en) clear_addr_reg <= clear_addr_reg + addr_t'(1);
            if (cmd.exec) begin
                cur_row_reg <= cur_row_next;
                cur_col_reg <= cur_col_next;
            end
            copy_pend_reg <= cmd.copy_en;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= in_operation;
            char_reg <= in_char_code;
            rrow_reg <= in_cell_row;
            rcol_reg <= in_cell_col;
        end
        if (cmd.exec) begin
            read_hit_reg <= (op_reg == OP_READ) && in_range;
            scrolled_reg <= need_scroll;
            scan_row_reg <= row_t'(1);
            scan_col_reg <= '0;
        end
        // scan walks rows 1..last over the used columns, then the bottom row
        if (cmd.copy_en || cmd.blank_en) begin
            if (scan_col_reg == LAST_COL) begin
                scan_col_reg <= '0;
                scan_row_reg <= scan_row_reg + row_t'(1);
            end else begin
                scan_col_reg <= scan_col_reg + col_t'(1);
            end
        end
        if (cmd.copy_en) copy_dst_reg <= copy_src - PITCH_A;
        if (cmd.load_out) begin
            out_value_reg <= read_hit_reg ? rdata_reg : '0;
            out_col_reg   <= cur_col_reg;
            out_row_reg   <= cur_row_reg;
            out_scr_reg   <= scrolled_reg;
        end
    end

    assign text_attribute = attr_reg;
    assign out_cell_value = out_value_reg;
    assign out_cursor_col = out_col_reg;
    assign out_cursor_row = out_row_reg;
    assign out_scrolled   = out_scr_reg;

endmodule

`default_nettype wire

// ----- sv/tcw_checker.sv -----
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks for the text console writer
// Watches the handshakes and result words on the top-level ports; bound
// to every instance of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_valid,
    input wire logic            s_ready,
    input wire logic            m_valid,
    input wire logic            m_ready,
    input wire tcw_pkg::cell_t  m_cell_value,
    input wire tcw_pkg::col_t   m_cursor_col,
    input wire tcw_pkg::row_t   m_cursor_row,
    input wire logic            m_scrolled
);
    import tcw_pkg::*;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_value) &&
        $stable(m_cursor_col) && $stable(m_cursor_row) && $stable(m_scrolled))
        else $error("result word changed while stalled");

    // One word at a time: ready drops after each acceptance
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // Cursor stays on screen
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cursor_col < col_t'(TEXT_COLUMNS)) &&
                    (m_cursor_row < row_t'(TEXT_ROWS)))
        else $error("cursor off screen");

    // A scroll leaves the cursor at the start of the bottom row, value zero
    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_scrolled |-> (m_cursor_row == LAST_ROW) &&
                                  (m_cursor_col == '0) && (m_cell_value == '0))
        else $error("bad cursor after scroll");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

`default_nettype wire

// ----- tb/text_console_checker.sv -----
// ----------------------------------------------------------------------------
// text_console_checker: scoreboard for the text console writer
// Watches the input, result and register channels. It keeps its own copy
// of the cell buffer, cursor and attribute, predicts one result per input
// word and compares every result word field by field, oldest first.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_checker #(
    parameter logic [2:0] ATTR_ADDR = 3'd0
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    // input channel
    input  wire logic            s_valid,
    input  wire logic            s_ready,
    input  wire logic            s_operation,
    input  wire tcw_pkg::char_t  s_char_code,
    input  wire tcw_pkg::row_t   s_cell_row,
    input  wire tcw_pkg::col_t   s_cell_col,
    // result channel
    input  wire logic            m_valid,
    input  wire logic            m_ready,
    input  wire tcw_pkg::cell_t  m_cell_value,
    input  wire tcw_pkg::col_t   m_cursor_col,
    input  wire tcw_pkg::row_t   m_cursor_row,
    input  wire logic            m_scrolled,
    // register port
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [2:0]      paddr,
    input  wire logic [31:0]     pwdata,
    input  wire logic            pready,
    // to the testbench top
    output int unsigned          mismatch_count,
    output int unsigned          words_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tcw_pkg::*;

    typedef struct packed {
        cell_t value;
        col_t  col;
        row_t  row;
        logic  scrolled;
    } console_result_t;

    // Shadow copy of the console
    cell_t           screen [CELL_COUNT];
    int unsigned     cur_x;
    int unsigned     cur_y;
    logic [7:0]      attr_byte;
    console_result_t console_results_q [$];
    int unsigned     err_n = 0;

    function automatic cell_t cell_at(input int unsigned idx);
        if (idx < CELL_COUNT)
            return screen[idx];
        return '0;
    endfunction

    function automatic void store_cell(input int unsigned idx, input cell_t v);
        if (idx < CELL_COUNT)
            screen[idx] = v;
    endfunction

    // Move rows up by one over the used columns, blank the bottom row
    function automatic void scroll_screen();
        cell_t blank;
        blank = {attr_byte, SPACE_CODE};
        for (int r = 0; r + 1 < TEXT_ROWS; r++)
            for (int c = 0; c < TEXT_COLUMNS; c++)
                store_cell(r * ROW_PITCH + c, cell_at((r + 1) * ROW_PITCH + c));
        for (int c = 0; c < TEXT_COLUMNS; c++)
            store_cell((TEXT_ROWS - 1) * ROW_PITCH + c, blank);
    endfunction

    // Returns 1 when the line feed pushed the screen up
    function automatic bit line_feed();
        cur_x = 0;
        cur_y++;
        if (cur_y >= TEXT_ROWS) begin
            cur_y = TEXT_ROWS - 1;
            scroll_screen();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void clear_console();
        foreach (screen[i])
            screen[i] = RESET_CELL;
        cur_x     = 0;
        cur_y     = 0;
        attr_byte = ATTR_RESET;
    endfunction

    function automatic void predict_word(input logic op, input char_t ch,
                                         input row_t rr, input col_t rc);
        console_result_t res;
        res = '0;
        if (op == OP_READ) begin
            if (int'(rr) < TEXT_ROWS && int'(rc) < ROW_PITCH)
                res.value = cell_at(int'(rr) * ROW_PITCH + int'(rc));
        end else if (ch == NEWLINE_CODE) begin
            res.scrolled = line_feed();
        end else begin
            store_cell(cur_y * ROW_PITCH + cur_x, {attr_byte, ch});
            cur_x++;
            if (cur_x >= TEXT_COLUMNS)
                res.scrolled = line_feed();
        end
        res.col = col_t'(cur_x);
        res.row = row_t'(cur_y);
        console_results_q.push_back(res);
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            err_n++;
            if (err_n <= 10)
                $display("ERROR %0t: %s expected 'h%0h, got 'h%0h",
                         $realtime, field, want, got);
        end
    endfunction

    always @(posedge aclk) begin : watch
        console_result_t want;
        if (!aresetn) begin
            clear_console();
            console_results_q.delete();
        end else begin
            // register write
            if (psel && penable && pwrite && pready && paddr == ATTR_ADDR)
                attr_byte = pwdata[7:0];
            // accepted input word
            if (s_valid && s_ready)
                predict_word(s_operation, s_char_code, s_cell_row, s_cell_col);
            // accepted result word
            if (m_valid && m_ready) begin
                if (console_results_q.size() == 0) begin
                    err_n++;
                    if (err_n <= 10)
                        $display("ERROR %0t: result word with nothing expected", $realtime);
                end else begin
                    want = console_results_q.pop_front();
                    check_field("cell_value", 32'(want.value), 32'(m_cell_value));
                    check_field("cursor_col", 32'(want.col), 32'(m_cursor_col));
                    check_field("cursor_row", 32'(want.row), 32'(m_cursor_row));
                    check_field("scrolled", 32'(want.scrolled), 32'(m_scrolled));
                end
            end
        end
        mismatch_count <= err_n;
        words_pending  <= console_results_q.size();
    end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: top of the text console writer test
// Drives reset, attribute register writes and input words, stalls the
// result side at random, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tcw_pkg::*;

    localparam int         CLK_PERIOD = 10;
    localparam logic [2:0] ATTR_ADDR  = 3'd0;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_operation = OP_PUT;
    char_t       s_char_code = '0;
    row_t        s_cell_row  = '0;
    col_t        s_cell_col  = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    cell_t       m_cell_value;
    col_t        m_cursor_col;
    row_t        m_cursor_row;
    logic        m_scrolled;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned mismatch_count;
    int unsigned words_pending;
    logic        send_quiet = 1'b0;
    logic        recv_quiet = 1'b0;
    int unsigned stall_left = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    text_console_writer dut (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_operation, .s_char_code, .s_cell_row, .s_cell_col,
        .m_valid, .m_ready, .m_cell_value, .m_cursor_col, .m_cursor_row, .m_scrolled,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    text_console_checker #(.ATTR_ADDR(ATTR_ADDR)) check (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_operation, .s_char_code, .s_cell_row, .s_cell_col,
        .m_valid, .m_ready, .m_cell_value, .m_cursor_col, .m_cursor_row, .m_scrolled,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .mismatch_count, .words_pending
    );

    // Result side: each word draws a random stall, none while recv_quiet is set
    always @(posedge aclk) begin : result_stall
        int unsigned n;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (m_valid && m_ready) begin
            n = recv_quiet ? 0 : $urandom_range(0, 19);
            stall_left <= n;
            m_ready    <= (n == 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= (stall_left == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic op, input char_t ch, input row_t rr, input col_t rc);
        int unsigned gap;
        gap = send_quiet ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_char_code <= ch;
        s_cell_row  <= rr;
        s_cell_col  <= rc;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Unused fields carry random bits
    task automatic put_char(input char_t ch);
        send_word(OP_PUT, ch, row_t'($urandom_range(0, 31)), col_t'($urandom_range(0, 127)));
    endtask

    task automatic read_cell(input int unsigned rr, input int unsigned rc);
        send_word(OP_READ, char_t'($urandom_range(0, 255)), row_t'(rr), col_t'(rc));
    endtask

    // Hold off until every result word is back and the block is ready
    task automatic wait_quiet();
        s_valid <= 1'b0;
        do @(posedge aclk); while (words_pending != 0 || !s_ready);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ATTR_ADDR;
        pwdata  <= {24'b0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random words: reads, line feeds and plain bytes at the given mix
    task automatic run_phase(input int count, input int nl_pct, input int rd_pct);
        int unsigned sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < rd_pct) begin
                if ($urandom_range(0, 4) == 0)
                    read_cell($urandom_range(0, 31), $urandom_range(0, 127));
                else
                    read_cell($urandom_range(0, TEXT_ROWS - 1), $urandom_range(0, ROW_PITCH - 1));
            end else if (sel < rd_pct + nl_pct) begin
                put_char(NEWLINE_CODE);
            end else begin
                put_char(char_t'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset attribute, reads at the edges, high bytes
        read_cell(0, 0);
        read_cell(TEXT_ROWS - 1, ROW_PITCH - 1);   // unused column
        read_cell(TEXT_ROWS - 1, ROW_PITCH);       // past the pitch
        read_cell(TEXT_ROWS, 0);                   // past the last row
        read_cell(31, 127);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h80);
        put_char(NEWLINE_CODE);
        read_cell(0, 0);
        read_cell(0, 1);
        read_cell(0, 2);
        read_cell(1, 0);

        wait_quiet();
        write_attribute(8'hFF);
        put_char(8'h7F);
        put_char(8'h41);
        read_cell(1, 0);
        read_cell(1, 1);
        put_char(NEWLINE_CODE);
        read_cell(0, TEXT_COLUMNS - 1);

        // long lines to force wraps
        wait_quiet();
        write_attribute(8'h00);
        run_phase(100, 1, 10);

        // many line feeds to scroll, sender back to back
        wait_quiet();
        write_attribute(8'($urandom_range(0, 255)));
        send_quiet <= 1'b1;
        run_phase(80, 35, 15);

        // no idling on either side
        wait_quiet();
        write_attribute(8'hFF);
        recv_quiet <= 1'b1;
        run_phase(60, 10, 30);

        // mixed traffic with idling again
        wait_quiet();
        write_attribute(8'($urandom_range(0, 255)));
        send_quiet <= 1'b0;
        recv_quiet <= 1'b0;
        run_phase(60, 15, 25);

        wait_quiet();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && words_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial begin
        #40ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
